/* hw/rtl/cltm_pkg.sv */
// ----------------------------------------------------------------------------
// Callback load and timing monitor package
// Field widths, opcodes, state encoding, transaction payloads and bin edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cltm_pkg;

   localparam int OPCODE_BITS    = 3;
   localparam int CB_BITS        = 24;
   localparam int BUF_BITS       = 24;
   localparam int CLIP_BITS      = 12;
   localparam int RATE_BITS      = 19;
   localparam int BLOCK_BITS     = 16;
   localparam int BIN_BITS       = 3;
   localparam int LOAD_BITS      = 18;
   localparam int LATENCY_BITS   = 24;
   localparam int SAMPLE_BITS    = 48;
   localparam int OUT_COUNT_BITS = 32;
   localparam int WEIGHT_BITS    = 16;
   localparam int BIN_COUNT      = 7;

   // cb * 25600 and block * 256000 as dividends
   localparam int LOAD_NUM_BITS  = 39;
   localparam int LAT_NUM_BITS   = 34;
   localparam int LOAD_MUL_BITS  = 31;   // cb * 100
   localparam int LAT_MUL_BITS   = 26;   // block * 1000

   localparam logic [WEIGHT_BITS-1:0] EMA_WEIGHT_RESET = 16'd6554;
   localparam logic [BIN_BITS-1:0]    NO_BIN           = 3'd7;

   // upper edge of each bin in us; the last bin takes the rest
   localparam logic [CB_BITS-1:0] BIN_EDGE_US [BIN_COUNT-1] =
      '{24'd500, 24'd1000, 24'd2000, 24'd5000, 24'd10000, 24'd20000};

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_UPDATE          = 3'd0,
      OP_UNDERRUN        = 3'd1,
      OP_CLEAR_UNDERRUNS = 3'd2,
      OP_RESET_PEAK      = 3'd3,
      OP_READ_BIN        = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [CB_BITS-1:0]     callback_time_us;
      logic [BUF_BITS-1:0]    buffer_time_us;
      logic [CLIP_BITS-1:0]   clips_active;
      logic [RATE_BITS-1:0]   rate_hz;
      logic [BLOCK_BITS-1:0]  block_samples;
      logic [BIN_BITS-1:0]    bin_select;
   } req_type;

   typedef struct packed {
      logic [LOAD_BITS-1:0]      load_smoothed;
      logic [LOAD_BITS-1:0]      load_peak;
      logic [LATENCY_BITS-1:0]   latency_ms;
      logic [OUT_COUNT_BITS-1:0] underruns;
      logic [CLIP_BITS-1:0]      clips_now;
      logic [SAMPLE_BITS-1:0]    samples_total;
      logic [BIN_BITS-1:0]       bin_index;
      logic [OUT_COUNT_BITS-1:0] bin_count;
   } rsp_type;

   // first bin whose edge is not below the callback time
   function automatic logic [BIN_BITS-1:0] bin_of(input logic [CB_BITS-1:0] cb);
      logic [BIN_BITS-1:0] b;
      b = BIN_BITS'(BIN_COUNT - 1);
      for (int i = BIN_COUNT - 2; i >= 0; i--) begin
         if (cb <= BIN_EDGE_US[i]) begin
            b = BIN_BITS'(i);
         end
      end
      return b;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/callback_load_timing_monitor_core.sv */
// ----------------------------------------------------------------------------
// Callback load and timing monitor
// Tracks instant, smoothed and peak load, buffer latency, sample and clip
// counts, underruns and a seven-bin callback time histogram.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------
//  req     | in  | req_valid / req_stall  | req_data  (cltm_pkg::req_type)
//  rsp     | out | rsp_valid / rsp_stall  | rsp_data  (cltm_pkg::rsp_type)
//  csr     | in  | csr_write_enable       | csr_write_data (ema weight)
//
//  Update: accepted in idle, then a launch state starts the 39-bit load divider
//  (latency divider alongside), then the serial EMA multiply and a commit;
//  the next request is taken only back in idle, after that commit.
//  Other opcodes go from acceptance straight to the commit state.
//  Synchronous reset clears all counters and load state; ema weight to 6554.
//  A held rsp blocks only the commit of the next transaction, not its accept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module callback_load_timing_monitor_core #(
   parameter int COUNTER_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  cltm_pkg::req_type                 req_data,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cltm_pkg::rsp_type                 rsp_data,

   input  logic                              csr_write_enable,
   input  logic [cltm_pkg::WEIGHT_BITS-1:0]  csr_write_data
);

   import cltm_pkg::*;

   localparam int ACC_BITS     = LOAD_BITS + 1 + WEIGHT_BITS;
   localparam int MUL_CNT_BITS = $clog2(WEIGHT_BITS);
   localparam int CNT_OUT_WIDE = (COUNTER_BITS > OUT_COUNT_BITS) ? COUNTER_BITS
                                                                 : OUT_COUNT_BITS;

   // ---- control ----
   state_type state_ff, state_in;
   logic      accept;
   logic      div_start;
   logic      commit;
   logic      out_free;

   // ---- transaction and working registers ----
   req_type                    req_ff, req_in;
   logic [BIN_BITS-1:0]        bin_idx_ff, bin_idx_in;
   logic [LOAD_BITS-1:0]       inst_ff, inst_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic [MUL_CNT_BITS-1:0]    mul_count_ff, mul_count_in;

   // ---- architectural state ----
   logic [WEIGHT_BITS-1:0]  ema_weight_ff, ema_weight_in;
   logic [LOAD_BITS-1:0]    smoothed_ff, smoothed_in;
   logic [LOAD_BITS-1:0]    peak_ff, peak_in;
   logic [LATENCY_BITS-1:0] latency_ff, latency_in;
   logic [COUNTER_BITS-1:0] underrun_ff, underrun_in;
   logic [CLIP_BITS-1:0]    clips_ff, clips_in;
   logic [SAMPLE_BITS-1:0]  samples_ff, samples_in;
   logic [COUNTER_BITS-1:0] bin_cnt_ff [BIN_COUNT];
   logic [COUNTER_BITS-1:0] bin_cnt_in [BIN_COUNT];

   // ---- output register ----
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // ---- dividers ----
   logic [LOAD_MUL_BITS-1:0]  cb_x100;
   logic [LAT_MUL_BITS-1:0]   block_x1000;
   logic                      load_done, lat_done;
   logic [LOAD_BITS-1:0]      load_quo;
   logic [LATENCY_BITS-1:0]   lat_quo;

   // cb * 100 = 64cb + 32cb + 4cb; block * 1000 = 1024b - 16b - 8b
   assign cb_x100 = (LOAD_MUL_BITS'(req_ff.callback_time_us) << 6)
                  + (LOAD_MUL_BITS'(req_ff.callback_time_us) << 5)
                  + (LOAD_MUL_BITS'(req_ff.callback_time_us) << 2);
   assign block_x1000 = (LAT_MUL_BITS'(req_ff.block_samples) << 10)
                      - (LAT_MUL_BITS'(req_ff.block_samples) << 4)
                      - (LAT_MUL_BITS'(req_ff.block_samples) << 3);

   cltm_divider #(
      .NUM_BITS (LOAD_NUM_BITS),
      .DEN_BITS (BUF_BITS),
      .QUO_BITS (LOAD_BITS)
   ) u_load_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   ({cb_x100, 8'h00}),
      .denominator (req_ff.buffer_time_us),
      .done        (load_done),
      .quotient    (load_quo)
   );

   cltm_divider #(
      .NUM_BITS (LAT_NUM_BITS),
      .DEN_BITS (RATE_BITS),
      .QUO_BITS (LATENCY_BITS)
   ) u_lat_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   ({block_x1000, 8'h00}),
      .denominator (req_ff.rate_hz),
      .done        (lat_done),
      .quotient    (lat_quo)
   );

   // ---- sequencer ----
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      accept    = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               accept   = 1'b1;
               state_in = (req_data.opcode == OP_UPDATE) ? ST_LOAD : ST_FINISH;
            end
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (load_done && lat_done) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            if (mul_count_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- working datapath ----
   logic signed [LOAD_BITS:0]  load_diff;
   logic signed [ACC_BITS-1:0] load_diff_ext;

   // EMA as s + w * (inst - s) / 2^16, w taken MSB first
   assign load_diff     = $signed({1'b0, inst_ff}) - $signed({1'b0, smoothed_ff});
   assign load_diff_ext = ACC_BITS'(load_diff);

   always_comb begin
      req_in       = req_ff;
      bin_idx_in   = bin_idx_ff;
      inst_in      = inst_ff;
      acc_in       = acc_ff;
      mul_count_in = mul_count_ff;
      if (accept) begin
         req_in = req_data;
      end
      if (state_ff == ST_LOAD) begin
         bin_idx_in = bin_of(req_ff.callback_time_us);
      end
      if (state_ff == ST_DIVIDE && load_done && lat_done) begin
         // zero buffer time reads as zero load
         inst_in      = (req_ff.buffer_time_us == '0) ? '0 : load_quo;
         acc_in       = '0;
         mul_count_in = MUL_CNT_BITS'(WEIGHT_BITS - 1);
      end
      if (state_ff == ST_MULTIPLY) begin
         acc_in       = (acc_ff <<< 1)
                      + (ema_weight_ff[mul_count_ff] ? load_diff_ext : '0);
         mul_count_in = mul_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      bin_idx_ff   <= bin_idx_in;
      inst_ff      <= inst_in;
      acc_ff       <= acc_in;
      mul_count_ff <= mul_count_in;
   end

   // ---- commit of state and result ----
   logic                     is_update;
   logic [ACC_BITS-1:0]      ema_shift;
   logic [LOAD_BITS:0]       ema_sum;
   logic [BIN_BITS-1:0]      bin_rd_idx;
   logic                     bin_rd_hit;
   logic [COUNTER_BITS-1:0]  bin_rd;
   logic [COUNTER_BITS-1:0]  bin_inc;
   logic [CNT_OUT_WIDE-1:0]  underrun_wide;
   logic [CNT_OUT_WIDE-1:0]  bin_wide;

   assign is_update  = (req_ff.opcode == OP_UPDATE);
   assign ema_shift  = ACC_BITS'(acc_ff >>> WEIGHT_BITS);
   assign ema_sum    = {1'b0, smoothed_ff} + ema_shift[LOAD_BITS:0];
   assign bin_rd_idx = is_update ? bin_idx_ff : req_ff.bin_select;
   assign bin_rd_hit = (bin_rd_idx != NO_BIN);
   assign bin_rd     = bin_rd_hit ? bin_cnt_ff[bin_rd_idx] : '0;
   assign bin_inc    = bin_rd + 1'b1;

   always_comb begin
      ema_weight_in = ema_weight_ff;
      smoothed_in   = smoothed_ff;
      peak_in       = peak_ff;
      latency_in    = latency_ff;
      underrun_in   = underrun_ff;
      clips_in      = clips_ff;
      samples_in    = samples_ff;
      bin_cnt_in    = bin_cnt_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;

      if (csr_write_enable) begin
         ema_weight_in = csr_write_data;
      end

      if (commit) begin
         case (req_ff.opcode)
            OP_UPDATE: begin
               smoothed_in = ema_sum[LOAD_BITS-1:0];
               if (inst_ff > peak_ff) begin
                  peak_in = inst_ff;
               end
               // zero rate holds the previous latency
               if (req_ff.rate_hz != '0) begin
                  latency_in = lat_quo;
               end
               clips_in   = req_ff.clips_active;
               samples_in = samples_ff + SAMPLE_BITS'(req_ff.block_samples);
               bin_cnt_in[bin_idx_ff] = bin_inc;
            end
            OP_UNDERRUN: begin
               underrun_in = underrun_ff + 1'b1;
            end
            OP_CLEAR_UNDERRUNS: begin
               underrun_in = '0;
            end
            OP_RESET_PEAK: begin
               peak_in = smoothed_ff;
            end
            default: begin
            end
         endcase
      end

      underrun_wide = CNT_OUT_WIDE'(underrun_in);
      bin_wide      = '0;
      if (is_update) begin
         bin_wide = CNT_OUT_WIDE'(bin_inc);
      end else if (req_ff.opcode == OP_READ_BIN) begin
         bin_wide = CNT_OUT_WIDE'(bin_rd);
      end

      if (commit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.load_smoothed = smoothed_in;
         rsp_data_in.load_peak     = peak_in;
         rsp_data_in.latency_ms    = latency_in;
         rsp_data_in.underruns     = underrun_wide[OUT_COUNT_BITS-1:0];
         rsp_data_in.clips_now     = clips_in;
         rsp_data_in.samples_total = samples_in;
         rsp_data_in.bin_count     = bin_wide[OUT_COUNT_BITS-1:0];
         if (is_update) begin
            rsp_data_in.bin_index = bin_idx_ff;
         end else if (req_ff.opcode == OP_READ_BIN) begin
            rsp_data_in.bin_index = req_ff.bin_select;
         end else begin
            rsp_data_in.bin_index = NO_BIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ema_weight_ff <= EMA_WEIGHT_RESET;
         smoothed_ff   <= '0;
         peak_ff       <= '0;
         latency_ff    <= '0;
         underrun_ff   <= '0;
         clips_ff      <= '0;
         samples_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < BIN_COUNT; i++) begin
            bin_cnt_ff[i] <= '0;
         end
      end else begin
         ema_weight_ff <= ema_weight_in;
         smoothed_ff   <= smoothed_in;
         peak_ff       <= peak_in;
         latency_ff    <= latency_in;
         underrun_ff   <= underrun_in;
         clips_ff      <= clips_in;
         samples_ff    <= samples_in;
         rsp_valid_ff  <= rsp_valid_in;
         bin_cnt_ff    <= bin_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/cltm_divider.sv */
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, dividend fed MSB first
// from a shift register. Quotient saturates to all ones on overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cltm_divider #(
   parameter int NUM_BITS = 39,
   parameter int DEN_BITS = 24,
   parameter int QUO_BITS = 18
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numerator,
   input  logic [DEN_BITS-1:0] denominator,
   output logic                done,
   output logic [QUO_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS+1:0] diff;
   logic                qbit;

   assign trial = {rem_ff, num_ff[NUM_BITS-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign qbit  = ~diff[DEN_BITS+1];

   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      if (start) begin
         num_in   = numerator;
         den_in   = denominator;
         rem_in   = '0;
         quo_in   = '0;
         ovf_in   = 1'b0;
         count_in = CNT_BITS'(NUM_BITS);
      end else if (count_ff != '0) begin
         num_in   = {num_ff[NUM_BITS-2:0], 1'b0};
         rem_in   = qbit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         // a one leaving the top of the quotient means saturation
         ovf_in   = ovf_ff | quo_ff[QUO_BITS-1];
         quo_in   = {quo_ff[QUO_BITS-2:0], qbit};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done     = (count_ff == '0);
   assign quotient = ovf_ff ? '1 : quo_ff;

endmodule

`default_nettype wire

/* tb/callback_load_timing_monitor_core_tb.sv */
// ----------------------------------------------------------------------------
// Callback load and timing monitor testbench
// Drives callback reports, underrun, peak and bin opcodes through the req
// channel, predicts every rsp transaction with a cycle-free model of the
// monitor state and checks each response field by field, across several
// ema weights and idling mixes, including a long rsp hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module callback_load_timing_monitor_core_tb;

   import cltm_pkg::*;

   // opcodes outside the decoded set; the core must leave state alone
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_HI = 3'd7;

   localparam logic [63:0] LOAD_LIMIT    = (64'd1 << LOAD_BITS) - 64'd1;
   localparam logic [63:0] LATENCY_LIMIT = (64'd1 << LATENCY_BITS) - 64'd1;
   localparam int          PHASE_ITEMS   = 275;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          SETTLE_CYCLES = 70;   // a little over one update

   // ------------------------------------------------------------------------
   // clock, reset and DUT ports; every bench-driven signal known from time zero
   // ------------------------------------------------------------------------
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [WEIGHT_BITS-1:0] csr_write_data   = '0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   callback_load_timing_monitor_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ------------------------------------------------------------------------
   // shared testbench state
   // ------------------------------------------------------------------------
   req_type queued_calls[$];     // transactions waiting to be offered
   rsp_type awaited_status[$];   // predicted responses, oldest first
   int      mismatch_count   = 0;
   int      sender_idle_pct  = 0;
   int      stall_pct        = 0;
   logic    req_taken        = 1'b0;   // req accepted at the last rising edge
   logic    hold_request     = 1'b0;   // toggled to start a long rsp hold-off
   logic    hold_seen        = 1'b0;
   int      hold_left        = 0;

   // model of the monitor state
   logic [WEIGHT_BITS-1:0]    weight_model;
   logic [LOAD_BITS-1:0]      smoothed_model;
   logic [LOAD_BITS-1:0]      peak_model;
   logic [LATENCY_BITS-1:0]   latency_model;
   logic [OUT_COUNT_BITS-1:0] underrun_model;
   logic [CLIP_BITS-1:0]      clip_model;
   logic [SAMPLE_BITS-1:0]    sample_model;
   logic [OUT_COUNT_BITS-1:0] bin_model [BIN_COUNT];

   // ------------------------------------------------------------------------
   // predictor: apply one transaction to the model, return the status it
   // should produce (state after the step)
   // ------------------------------------------------------------------------
   task automatic step_load_monitor(input req_type t, output rsp_type r);
      logic [63:0]         inst;
      logic [63:0]         lat;
      logic [63:0]         acc;
      logic [BIN_BITS-1:0] b;
      logic                found;
      int                  i;
      r           = '0;
      r.bin_index = NO_BIN;
      case (t.opcode)
         OP_UPDATE: begin
            sample_model = sample_model + SAMPLE_BITS'(t.block_samples);
            clip_model   = t.clips_active;
            // zero buffer time gives no load, but smoothing and peak still run
            inst = 64'd0;
            if (t.buffer_time_us != '0) begin
               inst = (64'(t.callback_time_us) * 64'd25600) / 64'(t.buffer_time_us);
               if (inst > LOAD_LIMIT) begin
                  inst = LOAD_LIMIT;
               end
            end
            acc = 64'(weight_model) * inst
                + (64'd65536 - 64'(weight_model)) * 64'(smoothed_model);
            smoothed_model = acc[LOAD_BITS+15:16];
            if (inst > 64'(peak_model)) begin
               peak_model = inst[LOAD_BITS-1:0];
            end
            // zero rate keeps the old latency
            if (t.rate_hz != '0) begin
               lat = (64'(t.block_samples) * 64'd256000) / 64'(t.rate_hz);
               latency_model = (lat > LATENCY_LIMIT) ? '1 : lat[LATENCY_BITS-1:0];
            end
            b     = BIN_BITS'(BIN_COUNT - 1);
            found = 1'b0;
            for (i = 0; i < BIN_COUNT - 1; i++) begin
               if (!found && t.callback_time_us <= BIN_EDGE_US[i]) begin
                  b     = BIN_BITS'(i);
                  found = 1'b1;
               end
            end
            bin_model[b] = bin_model[b] + 1'b1;
            r.bin_index  = b;
            r.bin_count  = bin_model[b];
         end
         OP_UNDERRUN: begin
            underrun_model = underrun_model + 1'b1;
         end
         OP_CLEAR_UNDERRUNS: begin
            underrun_model = '0;
         end
         OP_RESET_PEAK: begin
            peak_model = smoothed_model;
         end
         OP_READ_BIN: begin
            if (t.bin_select < BIN_COUNT) begin
               r.bin_index = t.bin_select;
               r.bin_count = bin_model[t.bin_select];
            end
         end
         default: begin
         end
      endcase
      r.load_smoothed = smoothed_model;
      r.load_peak     = peak_model;
      r.latency_ms    = latency_model;
      r.underruns     = underrun_model;
      r.clips_now     = clip_model;
      r.samples_total = sample_model;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------------
   // monitor: model update, req acceptance and rsp checking at rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      rsp_type next;
      if (reset) begin
         weight_model   = EMA_WEIGHT_RESET;
         smoothed_model = '0;
         peak_model     = '0;
         latency_model  = '0;
         underrun_model = '0;
         clip_model     = '0;
         sample_model   = '0;
         for (int i = 0; i < BIN_COUNT; i++) begin
            bin_model[i] = '0;
         end
         req_taken <= 1'b0;
      end else begin
         // check before predicting so a response never meets its own entry
         if (rsp_valid && !rsp_stall) begin
            if (awaited_status.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = awaited_status.pop_front();
               compare_field("load_smoothed", want.load_smoothed, rsp_data.load_smoothed);
               compare_field("load_peak",     want.load_peak,     rsp_data.load_peak);
               compare_field("latency_ms",    want.latency_ms,    rsp_data.latency_ms);
               compare_field("underruns",     want.underruns,     rsp_data.underruns);
               compare_field("clips_now",     want.clips_now,     rsp_data.clips_now);
               compare_field("samples_total", want.samples_total, rsp_data.samples_total);
               compare_field("bin_index",     want.bin_index,     rsp_data.bin_index);
               compare_field("bin_count",     want.bin_count,     rsp_data.bin_count);
            end
         end
         if (csr_write_enable) begin
            weight_model = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            step_load_monitor(req_data, next);
            awaited_status.push_back(next);
         end
         req_taken <= req_valid && !req_stall;
      end
   end

   // ------------------------------------------------------------------------
   // driver: falling edge; a stalled transaction is held unchanged
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_calls.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= queued_calls.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, or a long counted hold-off on request so the
   // core fills up and pushes back on req
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_type make_call(input logic [OPCODE_BITS-1:0] op,
                                         input logic [CB_BITS-1:0]     cb,
                                         input logic [BUF_BITS-1:0]    buffer_us,
                                         input logic [CLIP_BITS-1:0]   clips,
                                         input logic [RATE_BITS-1:0]   rate,
                                         input logic [BLOCK_BITS-1:0]  block,
                                         input logic [BIN_BITS-1:0]    sel);
      req_type t;
      t.opcode           = op;
      t.callback_time_us = cb;
      t.buffer_time_us   = buffer_us;
      t.clips_active     = clips;
      t.rate_hz          = rate;
      t.block_samples    = block;
      t.bin_select       = sel;
      return t;
   endfunction

   // mostly realistic callback reports, with edge-hugging and raw noise
   function automatic req_type random_call();
      req_type     t;
      int unsigned pick;
      t    = '0;
      pick = $urandom_range(99);
      if (pick < 62) begin
         t.opcode = OP_UPDATE;
      end else if (pick < 70) begin
         t.opcode = OP_UNDERRUN;
      end else if (pick < 74) begin
         t.opcode = OP_CLEAR_UNDERRUNS;
      end else if (pick < 82) begin
         t.opcode = OP_RESET_PEAK;
      end else if (pick < 95) begin
         t.opcode = OP_READ_BIN;
      end else begin
         t.opcode = OPCODE_BITS'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end
      case ($urandom_range(3))
         0:       t.callback_time_us = CB_BITS'($urandom);
         1:       t.callback_time_us = CB_BITS'($urandom_range(1200));
         2:       t.callback_time_us = CB_BITS'($urandom_range(25000));
         default: t.callback_time_us = BIN_EDGE_US[$urandom_range(BIN_COUNT - 2)]
                                       + CB_BITS'($urandom_range(2)) - CB_BITS'(1);
      endcase
      case ($urandom_range(9))
         0:       t.buffer_time_us = '0;
         1:       t.buffer_time_us = BUF_BITS'($urandom);
         2:       t.buffer_time_us = BUF_BITS'($urandom_range(16, 1));
         default: t.buffer_time_us = BUF_BITS'($urandom_range(25000, 500));
      endcase
      t.clips_active = CLIP_BITS'($urandom);
      case ($urandom_range(9))
         0:       t.rate_hz = '0;
         1:       t.rate_hz = RATE_BITS'($urandom);
         2:       t.rate_hz = RATE_BITS'($urandom_range(255, 1));
         3:       t.rate_hz = RATE_BITS'(44100);
         4:       t.rate_hz = RATE_BITS'(96000);
         5:       t.rate_hz = RATE_BITS'(192000);
         6:       t.rate_hz = RATE_BITS'(400000);
         default: t.rate_hz = RATE_BITS'(48000);
      endcase
      if ($urandom_range(3) == 0) begin
         t.block_samples = BLOCK_BITS'($urandom);
      end else begin
         t.block_samples = BLOCK_BITS'($urandom_range(4096, 16));
      end
      t.bin_select = BIN_BITS'($urandom);
      return t;
   endfunction

   // sampled just after a rising edge, when nothing is mid-update
   task automatic wait_quiet();
      do begin
         @(posedge clock);
         #1;
      end while (queued_calls.size() != 0 || req_valid || awaited_status.size() != 0);
   endtask

   // settle, load a weight and an idling mix, then queue random traffic
   task automatic run_phase(input logic [WEIGHT_BITS-1:0] weight, input int idle_pct,
                            input int stall_mix, input logic squeeze, input int count);
      wait_quiet();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= weight;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sender_idle_pct = idle_pct;
      stall_pct       = stall_mix;
      if (squeeze) begin
         hold_request = !hold_request;
      end
      for (int n = 0; n < count; n++) begin
         queued_calls.push_back(random_call());
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: bin edges, both saturations, zero buffer and zero rate,
      // every opcode, out-of-range bin read and spare opcodes
      queued_calls.push_back(make_call(OP_UPDATE, 24'd0, 24'd1000, 12'd0, 19'd48000,
                                       16'd0, 3'd0));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd500, 24'd0, 12'hFFF, 19'd0,
                                       16'hFFFF, 3'd7));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd501, 24'd1000, 12'd5, 19'd48000,
                                       16'd256, 3'd1));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd1000, 24'd1000, 12'd1, 19'd0,
                                       16'd128, 3'd2));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd2000, 24'd2000, 12'd9, 19'h7FFFF,
                                       16'hFFFF, 3'd3));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd5000, 24'd10000, 12'd2, 19'd1,
                                       16'hFFFF, 3'd4));
      queued_calls.push_back(make_call(OP_UPDATE, 24'hFFFFFF, 24'd1, 12'd0, 19'd44100,
                                       16'd512, 3'd5));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd10000, 24'hFFFFFF, 12'd3, 19'd96000,
                                       16'd64, 3'd6));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd20000, 24'd20000, 12'd4, 19'd48000,
                                       16'd960, 3'd0));
      queued_calls.push_back(make_call(OP_UPDATE, 24'd20001, 24'd5000, 12'd7, 19'd48000,
                                       16'd240, 3'd0));
      queued_calls.push_back(make_call(OP_UNDERRUN, '0, '0, '0, '0, '0, '0));
      queued_calls.push_back(make_call(OP_UNDERRUN, '1, '1, '1, '1, '1, '1));
      queued_calls.push_back(make_call(OP_RESET_PEAK, '0, '0, '0, '0, '0, '0));
      queued_calls.push_back(make_call(OP_READ_BIN, '0, '0, '0, '0, '0, 3'd0));
      queued_calls.push_back(make_call(OP_READ_BIN, '0, '0, '0, '0, '0, 3'd3));
      queued_calls.push_back(make_call(OP_READ_BIN, '0, '0, '0, '0, '0, 3'd6));
      queued_calls.push_back(make_call(OP_READ_BIN, '0, '0, '0, '0, '0, NO_BIN));
      queued_calls.push_back(make_call(OP_CLEAR_UNDERRUNS, '0, '0, '0, '0, '0, '0));
      queued_calls.push_back(make_call(OP_UNDERRUN, '0, '0, '0, '0, '0, '0));
      queued_calls.push_back(make_call(OP_SPARE_LO, 24'd700, 24'd1000, 12'd1, 19'd48000,
                                       16'd64, 3'd1));
      queued_calls.push_back(make_call(OP_SPARE_HI, '1, '1, '1, '1, '1, '1));

      // full weight with a long rsp hold-off, then zero weight, then random
      run_phase(16'hFFFF, 0, 0, 1'b1, PHASE_ITEMS);
      run_phase(16'h0000, 47, 0, 1'b0, PHASE_ITEMS);
      run_phase(WEIGHT_BITS'($urandom), 0, 47, 1'b0, PHASE_ITEMS);
      run_phase(WEIGHT_BITS'($urandom), 11, 11, 1'b0, PHASE_ITEMS);

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      #1;
      if (awaited_status.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d responses still expected, actual none",
                  $time, awaited_status.size());
      end
      if (mismatch_count == 0) begin
         $display("PASS callback_load_timing_monitor_core");
      end else begin
         $display("FAIL callback_load_timing_monitor_core");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL callback_load_timing_monitor_core");
      $finish;
   end

endmodule
